>>> sv/gamepad_radial_deadzone_assert.svh
// Assertion macros shared by the checker of the gamepad radial dead zone block.
`ifndef GAMEPAD_RADIAL_DEADZONE_ASSERT_SVH
`define GAMEPAD_RADIAL_DEADZONE_ASSERT_SVH

// Clocked assertion, quiet while reset is held
`define GPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define GPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/gpr_pkg.sv
// Shared types, constants and register codes of the gamepad radial dead zone block.
package gpr_pkg;

  localparam int unsigned AxisWidthDefault = 16;
  // direction is a * 2^16 / (2m), i.e. Q1.15 rounded
  localparam int unsigned FracBits   = 16;
  localparam int unsigned QuoWidth   = 17;
  localparam int unsigned LevelWidth = 15;
  localparam int unsigned CfgDataW   = 15;

  localparam logic [14:0] DeadZoneLeftReset  = 15'd7849;
  localparam logic [14:0] DeadZoneRightReset = 15'd8689;
  localparam logic [14:0] FullScaleReset     = 15'd32767;
  localparam logic [7:0]  TrigThreshReset    = 8'd30;

  typedef enum logic [1:0] {
    RegDeadZoneLeft  = 2'd0,
    RegDeadZoneRight = 2'd1,
    RegFullScale     = 2'd2,
    RegTrigThresh    = 2'd3
  } gpr_reg_e;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic [15:0]        button_word;
    logic               pad_present;
  } gpr_in_t;

  typedef struct packed {
    logic signed [15:0] left_dir_x;
    logic signed [15:0] left_dir_y;
    logic [14:0]        left_level;
    logic [15:0]        left_level_norm;
    logic signed [15:0] right_dir_x;
    logic signed [15:0] right_dir_y;
    logic [14:0]        right_level;
    logic [15:0]        right_level_norm;
    logic [7:0]         left_trigger_out;
    logic [7:0]         right_trigger_out;
    logic [15:0]        buttons_out;
  } gpr_out_t;

  typedef struct packed {
    gpr_reg_e              reg_index;
    logic [CfgDataW-1:0]   wdata;
  } gpr_cfg_t;

  // square, sum, one stage per root bit, round, level, then the divider steps
  function automatic int unsigned lane_latency(int unsigned aw);
    return aw + 4 + QuoWidth;
  endfunction

endpackage

>>> sv/gpr_chan_if.sv
// Valid/ready channel carrying one payload beat.
interface gpr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/gamepad_radial_deadzone.sv
// Throughput: one poll per cycle while the output is not stalled; the square root and the three dividers per stick
// are fully pipelined, one root bit or quotient bit per stage.
// The whole pipeline stalls only while an output beat waits to be taken.
// Reset (async, active low) clears all valid bits and loads the register defaults.
// Top level of the gamepad radial dead zone block: config, two stick lanes, merge.
module gamepad_radial_deadzone #(
  parameter int unsigned AXIS_WIDTH = gpr_pkg::AxisWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gpr_chan_if.sink      in_ch,
  gpr_chan_if.source    out_ch,
  gpr_chan_if.sink      cfg_ch
);
  import gpr_pkg::*;

  localparam int unsigned LaneLat = lane_latency(AXIS_WIDTH);

  typedef struct packed {
    logic [7:0]  lt;
    logic [7:0]  rt;
    logic [15:0] btn;
  } side_t;

  // configuration registers
  logic [14:0] dz_left_q, dz_right_q, fs_q;
  logic [7:0]  thr_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_left_q  <= DeadZoneLeftReset;
      dz_right_q <= DeadZoneRightReset;
      fs_q       <= FullScaleReset;
      thr_q      <= TrigThreshReset;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.payload.reg_index)
        RegDeadZoneLeft:  dz_left_q  <= cfg_ch.payload.wdata;
        RegDeadZoneRight: dz_right_q <= cfg_ch.payload.wdata;
        RegFullScale:     fs_q       <= cfg_ch.payload.wdata;
        RegTrigThresh:    thr_q      <= cfg_ch.payload.wdata[7:0];
      endcase
    end
  end

  // global advance: move whenever the output slot is free or being emptied
  logic     out_valid_q;
  gpr_out_t out_q;
  logic     en, lane_in_vld;

  assign en          = !out_valid_q || out_ch.ready;
  assign in_ch.ready = en;
  assign lane_in_vld = in_ch.valid && in_ch.payload.pad_present;

  // stick lanes
  logic        lv, rv;
  logic [15:0] l_dx, l_dy, l_nrm, r_dx, r_dy, r_nrm;
  logic [14:0] l_lvl, r_lvl;

  gpr_lane #(.AXIS_WIDTH(AXIS_WIDTH)) u_lane_left (
    .clk_i, .rst_ni,
    .en_i         (en),
    .valid_i      (lane_in_vld),
    .x_i          (in_ch.payload.left_x[AXIS_WIDTH-1:0]),
    .y_i          (in_ch.payload.left_y[AXIS_WIDTH-1:0]),
    .dead_zone_i  (dz_left_q),
    .full_scale_i (fs_q),
    .valid_o      (lv),
    .dir_x_o      (l_dx),
    .dir_y_o      (l_dy),
    .level_o      (l_lvl),
    .norm_o       (l_nrm)
  );

  gpr_lane #(.AXIS_WIDTH(AXIS_WIDTH)) u_lane_right (
    .clk_i, .rst_ni,
    .en_i         (en),
    .valid_i      (lane_in_vld),
    .x_i          (in_ch.payload.right_x[AXIS_WIDTH-1:0]),
    .y_i          (in_ch.payload.right_y[AXIS_WIDTH-1:0]),
    .dead_zone_i  (dz_right_q),
    .full_scale_i (fs_q),
    .valid_o      (rv),
    .dir_x_o      (r_dx),
    .dir_y_o      (r_dy),
    .level_o      (r_lvl),
    .norm_o       (r_nrm)
  );

  // triggers and buttons, delayed to line up with the lanes
  side_t side_d;
  side_t side_q [LaneLat];

  assign side_d.lt  = (in_ch.payload.left_trigger < thr_q) ? '0 : in_ch.payload.left_trigger;
  assign side_d.rt  = (in_ch.payload.right_trigger < thr_q) ? '0 : in_ch.payload.right_trigger;
  assign side_d.btn = in_ch.payload.button_word;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
    end
  end

  for (genvar k = 1; k < LaneLat; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // merge stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= lv && rv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.left_dir_x        <= l_dx;
      out_q.left_dir_y        <= l_dy;
      out_q.left_level        <= l_lvl;
      out_q.left_level_norm   <= l_nrm;
      out_q.right_dir_x       <= r_dx;
      out_q.right_dir_y       <= r_dy;
      out_q.right_level       <= r_lvl;
      out_q.right_level_norm  <= r_nrm;
      out_q.left_trigger_out  <= side_q[LaneLat-1].lt;
      out_q.right_trigger_out <= side_q[LaneLat-1].rt;
      out_q.buttons_out       <= side_q[LaneLat-1].btn;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_q;

endmodule

>>> sv/gpr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module gpr_div #(
  parameter int unsigned NUM_W  = 32,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned QUO_W  = 17,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [QUO_W];
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  low_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic              p_vld;
    logic [DEN_W-1:0]  p_rem;
    logic [QUO_W-1:0]  p_low;
    logic [DEN_W-1:0]  p_den;
    logic [SIDE_W-1:0] p_side;
    logic [DEN_W:0]    trial;
    logic              fits;

    if (i == 0) begin : g_first
      // high part of the numerator is already below the divisor
      assign p_vld  = valid_i;
      assign p_rem  = DEN_W'(num_i >> QUO_W);
      assign p_low  = num_i[QUO_W-1:0];
      assign p_den  = den_i;
      assign p_side = side_i;
    end else begin : g_next
      assign p_vld  = vld_q[i-1];
      assign p_rem  = rem_q[i-1];
      assign p_low  = low_q[i-1];
      assign p_den  = den_q[i-1];
      assign p_side = side_q[i-1];
    end

    assign trial = {p_rem, p_low[QUO_W-1]};
    assign fits  = trial >= {1'b0, p_den};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= fits ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];
        low_q[i]  <= {p_low[QUO_W-2:0], fits};
        den_q[i]  <= p_den;
        side_q[i] <= p_side;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = low_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

>>> sv/gpr_lane.sv
// One thumbstick lane: magnitude, rounded root, dead zone level and the three divisions.
module gpr_lane #(
  parameter int unsigned AXIS_WIDTH = gpr_pkg::AxisWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [AXIS_WIDTH-1:0] x_i,
  input  logic [AXIS_WIDTH-1:0] y_i,
  input  logic [14:0]           dead_zone_i,
  input  logic [14:0]           full_scale_i,
  output logic                  valid_o,
  output logic [15:0]           dir_x_o,
  output logic [15:0]           dir_y_o,
  output logic [14:0]           level_o,
  output logic [15:0]           norm_o
);
  import gpr_pkg::*;

  localparam int unsigned AW     = AXIS_WIDTH;
  localparam int unsigned SW     = 2 * AW;
  localparam int unsigned DNUM_W = AW + FracBits + 1;
  localparam int unsigned DDEN_W = AW + 1;
  localparam int unsigned NNUM_W = LevelWidth + FracBits;
  localparam int unsigned CMP_W  = (AW > LevelWidth) ? AW : LevelWidth;

  // saturate a rounded direction quotient into Q1.15
  function automatic logic [15:0] dir_sat(logic [QuoWidth-1:0] q, logic neg, logic zero);
    logic [15:0] res;
    if (zero) begin
      res = '0;
    end else if (neg) begin
      res = (q >= (QuoWidth'(1) << 15)) ? 16'h8000 : 16'(~q[15:0] + 16'd1);
    end else begin
      res = (q > QuoWidth'(16'h7FFF)) ? 16'h7FFF : q[15:0];
    end
    return res;
  endfunction

  // absolute values and squares
  logic [AW-1:0] ax, ay;
  assign ax = x_i[AW-1] ? AW'(~x_i + 1'b1) : x_i;
  assign ay = y_i[AW-1] ? AW'(~y_i + 1'b1) : y_i;

  logic          sq_vld_q;
  logic [SW-1:0] sqx_q, sqy_q;
  logic [AW-1:0] sq_ax_q, sq_ay_q;
  logic          sq_sx_q, sq_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else if (en_i) begin
      sq_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q   <= SW'(ax) * SW'(ax);
      sqy_q   <= SW'(ay) * SW'(ay);
      sq_ax_q <= ax;
      sq_ay_q <= ay;
      sq_sx_q <= x_i[AW-1];
      sq_sy_q <= y_i[AW-1];
    end
  end

  // digit-by-digit square root, one root bit per stage
  logic          rt_vld_q [AW+1];
  logic [SW-1:0] rt_rem_q [AW+1];
  logic [SW-1:0] rt_r_q   [AW+1];
  logic [AW-1:0] rt_ax_q  [AW+1];
  logic [AW-1:0] rt_ay_q  [AW+1];
  logic          rt_sx_q  [AW+1];
  logic          rt_sy_q  [AW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      rt_vld_q[0] <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_rem_q[0] <= sqx_q + sqy_q;
      rt_r_q[0]   <= '0;
      rt_ax_q[0]  <= sq_ax_q;
      rt_ay_q[0]  <= sq_ay_q;
      rt_sx_q[0]  <= sq_sx_q;
      rt_sy_q[0]  <= sq_sy_q;
    end
  end

  for (genvar s = 1; s <= AW; s++) begin : g_root
    localparam logic [SW-1:0] Bit = SW'(1) << (2 * (AW - s));
    logic [SW-1:0] trial;
    logic          take;

    assign trial = rt_r_q[s-1] + Bit;
    assign take  = rt_rem_q[s-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_vld_q[s] <= 1'b0;
      end else if (en_i) begin
        rt_vld_q[s] <= rt_vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_rem_q[s] <= take ? rt_rem_q[s-1] - trial : rt_rem_q[s-1];
        rt_r_q[s]   <= take ? (rt_r_q[s-1] >> 1) + Bit : rt_r_q[s-1] >> 1;
        rt_ax_q[s]  <= rt_ax_q[s-1];
        rt_ay_q[s]  <= rt_ay_q[s-1];
        rt_sx_q[s]  <= rt_sx_q[s-1];
        rt_sy_q[s]  <= rt_sy_q[s-1];
      end
    end
  end

  // round to nearest: bump when remainder exceeds the root
  logic          rd_vld_q;
  logic [AW-1:0] m_q, rd_ax_q, rd_ay_q;
  logic          rd_sx_q, rd_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (en_i) begin
      rd_vld_q <= rt_vld_q[AW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q     <= rt_r_q[AW][AW-1:0] + AW'(rt_rem_q[AW] > rt_r_q[AW]);
      rd_ax_q <= rt_ax_q[AW];
      rd_ay_q <= rt_ay_q[AW];
      rd_sx_q <= rt_sx_q[AW];
      rd_sy_q <= rt_sy_q[AW];
    end
  end

  // clamp, dead zone and division operands
  logic [14:0] mc, level, span;
  assign mc    = (CMP_W'(m_q) > CMP_W'(full_scale_i)) ? full_scale_i : 15'(m_q);
  assign level = (mc > dead_zone_i) ? 15'(mc - dead_zone_i) : '0;
  assign span  = 15'(full_scale_i - dead_zone_i);

  logic              lv_vld_q;
  logic [DNUM_W-1:0] numx_q, numy_q;
  logic [DDEN_W-1:0] den_q;
  logic              zero_q, lv_sx_q, lv_sy_q;
  logic [NNUM_W-1:0] nnum_q;
  logic [14:0]       span_q, level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_vld_q <= 1'b0;
    end else if (en_i) begin
      lv_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numx_q  <= (DNUM_W'(rd_ax_q) << FracBits) + DNUM_W'(m_q);
      numy_q  <= (DNUM_W'(rd_ay_q) << FracBits) + DNUM_W'(m_q);
      den_q   <= {m_q, 1'b0};
      zero_q  <= (m_q == '0);
      lv_sx_q <= rd_sx_q;
      lv_sy_q <= rd_sy_q;
      nnum_q  <= {level, FracBits'(0)};
      span_q  <= span;
      level_q <= level;
    end
  end

  // three dividers side by side
  logic                vx, vy, vn;
  logic [QuoWidth-1:0] qx, qy, qn;
  logic [1:0]          sbx, sby;
  logic [14:0]         lvl;

  gpr_div #(.NUM_W(DNUM_W), .DEN_W(DDEN_W), .QUO_W(QuoWidth), .SIDE_W(2)) u_div_x (
    .clk_i, .rst_ni, .en_i,
    .valid_i (lv_vld_q),
    .num_i   (numx_q),
    .den_i   (den_q),
    .side_i  ({lv_sx_q, zero_q}),
    .valid_o (vx),
    .quo_o   (qx),
    .side_o  (sbx)
  );

  gpr_div #(.NUM_W(DNUM_W), .DEN_W(DDEN_W), .QUO_W(QuoWidth), .SIDE_W(2)) u_div_y (
    .clk_i, .rst_ni, .en_i,
    .valid_i (lv_vld_q),
    .num_i   (numy_q),
    .den_i   (den_q),
    .side_i  ({lv_sy_q, zero_q}),
    .valid_o (vy),
    .quo_o   (qy),
    .side_o  (sby)
  );

  gpr_div #(.NUM_W(NNUM_W), .DEN_W(LevelWidth), .QUO_W(QuoWidth), .SIDE_W(LevelWidth)) u_div_n (
    .clk_i, .rst_ni, .en_i,
    .valid_i (lv_vld_q),
    .num_i   (nnum_q),
    .den_i   (span_q),
    .side_i  (level_q),
    .valid_o (vn),
    .quo_o   (qn),
    .side_o  (lvl)
  );

  // saturation of the quotients
  assign valid_o = vx & vy & vn;
  assign dir_x_o = dir_sat(qx, sbx[1], sbx[0]);
  assign dir_y_o = dir_sat(qy, sby[1], sby[0]);
  assign level_o = lvl;
  assign norm_o  = (lvl == '0) ? '0 : (qn[QuoWidth-1] ? 16'hFFFF : qn[15:0]);

endmodule

>>> sv/gpr_checker.sv
// Port-level checks of the gamepad radial dead zone block, bound to the top level.
module gpr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             cfg_ready_i,
  input gpr_pkg::gpr_out_t out_beat_i
);
  `include "gamepad_radial_deadzone_assert.svh"

  // a stalled output beat holds
  `GPR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_beat_i), "output beat changed while stalled")

  // input is refused only while the output slot is blocked
  `GPR_ASSERT(a_in_ready, in_ready_i == (!out_valid_i || out_ready_i), "input ready does not follow output stall")

  // config writes are never back-pressured
  `GPR_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_i, "config ready dropped")

  // a nonzero level always normalizes to a nonzero value, and zero to zero
  `GPR_ASSERT(a_left_norm, out_valid_i |-> ((out_beat_i.left_level == '0) == (out_beat_i.left_level_norm == '0)), "left level and norm disagree")
  `GPR_ASSERT(a_right_norm, out_valid_i |-> ((out_beat_i.right_level == '0) == (out_beat_i.right_level_norm == '0)), "right level and norm disagree")

  logic unused_in_valid;
  assign unused_in_valid = in_valid_i;

endmodule

bind gamepad_radial_deadzone gpr_checker u_gpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .cfg_ready_i (cfg_ch.ready),
  .out_beat_i  (out_ch.payload)
);
